// File: rtl/priority_ready_queue_scheduler_defines.svh
// Assertion helpers shared by the RTL.
`ifndef PRIORITY_READY_QUEUE_SCHEDULER_DEFINES_SVH
`define PRIORITY_READY_QUEUE_SCHEDULER_DEFINES_SVH

// Same-cycle implication, masked while reset is high.
`define PRQS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, masked while reset is high.
`define PRQS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/prqs_pkg.sv
package prqs_pkg;

   localparam int ID_W   = 5;
   localparam int PRIO_W = 5;

   // ready-bit scan: lanes per group, and the index width within a group
   localparam int LANES  = 8;
   localparam int LANE_W = 3;

   typedef enum logic [1:0] {
      FUNC_ENQ_TAIL = 2'd0,
      FUNC_ENQ_HEAD = 2'd1,
      FUNC_DEQ_NEXT = 2'd2,
      FUNC_YIELD    = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      STATUS_OK     = 2'd0,
      STATUS_EMPTY  = 2'd1,
      STATUS_QUEUED = 2'd2
   } status_type;

   typedef struct packed {
      func_type          func;
      logic [ID_W-1:0]   tid;
      logic [PRIO_W-1:0] priority_req;
   } req_type;

   typedef struct packed {
      logic [ID_W-1:0] chosen_id;
      logic            chosen_valid;
      status_type      status;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic latch;
      logic enq_check;
      logic enq_rd;
      logic enq_wr;
      logic scan;
      logic deq_rd;
      logic deq_link;
      logic deq_wr;
      logic load_rsp;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic enq_skip;
      logic deq_any;
      logic rsp_busy;
   } stat_type;

endpackage

// File: rtl/prqs_ctrl.sv
module prqs_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  prqs_pkg::func_type req_func,
   output logic               req_ready,
   input  prqs_pkg::stat_type stat,
   output prqs_pkg::cmd_type  cmd
);
   import prqs_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_ENQ_RD,
      S_ENQ_WR,
      S_DEQ_SCAN,
      S_DEQ_RD,
      S_DEQ_LINK,
      S_DEQ_WR,
      S_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      yield_ff, yield_in;
   logic      ready_ff;

   always_comb begin
      state_in = state_ff;
      yield_in = yield_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid && ready_ff) begin
               cmd.latch = 1'b1;
               yield_in  = (req_func == FUNC_YIELD);
               if (req_func inside {FUNC_ENQ_TAIL, FUNC_ENQ_HEAD, FUNC_YIELD}) begin
                  state_in = S_ENQ_RD;
               end else begin
                  state_in = S_DEQ_SCAN;
               end
            end
         end
         S_ENQ_RD: begin
            if (stat.enq_skip) begin
               cmd.enq_check = 1'b1;
               state_in      = yield_ff ? S_DEQ_SCAN : S_DONE;
            end else begin
               cmd.enq_rd = 1'b1;
               state_in   = S_ENQ_WR;
            end
         end
         S_ENQ_WR: begin
            cmd.enq_wr = 1'b1;
            state_in   = yield_ff ? S_DEQ_SCAN : S_DONE;
         end
         S_DEQ_SCAN: begin
            cmd.scan = 1'b1;
            state_in = S_DEQ_RD;
         end
         S_DEQ_RD: begin
            cmd.deq_rd = 1'b1;
            state_in   = stat.deq_any ? S_DEQ_LINK : S_DONE;
         end
         S_DEQ_LINK: begin
            cmd.deq_link = 1'b1;
            state_in     = S_DEQ_WR;
         end
         S_DEQ_WR: begin
            cmd.deq_wr = 1'b1;
            state_in   = S_DONE;
         end
         S_DONE: begin
            if (!stat.rsp_busy) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         yield_ff <= 1'b0;
         ready_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         yield_ff <= yield_in;
         ready_ff <= (state_in == S_IDLE);
      end
   end

   assign req_ready = ready_ff;

endmodule

// File: rtl/prqs_dpath.sv
module prqs_dpath #(
   parameter int NUM_PRIORITIES = 32,
   parameter int NUM_THREADS    = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  prqs_pkg::req_type req_data,
   input  prqs_pkg::cmd_type cmd,
   output prqs_pkg::stat_type stat,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output prqs_pkg::rsp_type rsp_data
);
   import prqs_pkg::*;

   localparam int PW = $clog2(NUM_PRIORITIES);
   localparam int TW = $clog2(NUM_THREADS);
   localparam int NG = (NUM_PRIORITIES + LANES - 1) / LANES;
   localparam int GW = (NG > 1) ? $clog2(NG) : 1;

   // latched request
   func_type      func_ff;
   logic [TW-1:0] tid_ff;
   logic          tid_ok_ff;
   logic [PW-1:0] prio_ff;
   logic [PW-1:0] prio_in;

   // queue state
   logic [NUM_PRIORITIES-1:0] ready_ff;
   logic [NUM_THREADS-1:0]    queued_ff;
   logic [TW-1:0]             head_mem [NUM_PRIORITIES];
   logic [TW-1:0]             tail_mem [NUM_PRIORITIES];
   logic [TW-1:0]             link_mem [NUM_THREADS];
   logic [TW-1:0]             head_rd_ff, tail_rd_ff, link_rd_ff;
   logic [PW-1:0]             rd_addr;

   // ready-bit scan
   logic [NG*LANES-1:0] ready_pad;
   logic [NG-1:0]       grp_any_in, grp_any_ff;
   logic [LANE_W-1:0]   grp_idx_in [NG];
   logic [LANE_W-1:0]   grp_idx_ff [NG];
   logic [GW-1:0]       g_sel;
   logic [LANE_W-1:0]   i_sel;
   logic [PW-1:0]       p_sel;

   // dequeue / result
   logic [PW-1:0] deq_prio_ff;
   logic [TW-1:0] chosen_ff;
   logic          tail_hit_ff;
   logic          valid_ff;
   status_type    status_ff;
   logic          at_head;
   logic          rsp_valid_ff;
   rsp_type       rsp_data_ff;

   assign prio_in = (int'(req_data.priority_req) >= NUM_PRIORITIES) ?
                    PW'(NUM_PRIORITIES - 1) : PW'(req_data.priority_req);
   assign at_head = (func_ff == FUNC_ENQ_HEAD);

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         func_ff   <= req_data.func;
         tid_ff    <= TW'(req_data.tid);
         tid_ok_ff <= (int'(req_data.tid) < NUM_THREADS);
         prio_ff   <= prio_in;
      end
   end

   // lowest set bit: first within groups of eight, then across groups
   assign ready_pad = (NG*LANES)'(ready_ff);

   always_comb begin
      for (int g = 0; g < NG; g++) begin
         grp_any_in[g] = |ready_pad[g*LANES +: LANES];
         grp_idx_in[g] = '0;
         for (int i = LANES - 1; i >= 0; i--) begin
            if (ready_pad[g*LANES + i]) begin
               grp_idx_in[g] = LANE_W'(i);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan) begin
         grp_any_ff <= grp_any_in;
         grp_idx_ff <= grp_idx_in;
      end
   end

   always_comb begin
      g_sel = '0;
      i_sel = '0;
      for (int g = NG - 1; g >= 0; g--) begin
         if (grp_any_ff[g]) begin
            g_sel = GW'(g);
            i_sel = grp_idx_ff[g];
         end
      end
   end

   assign p_sel   = PW'({g_sel, i_sel});
   assign rd_addr = cmd.deq_rd ? p_sel : prio_ff;

   // memories
   always_ff @(posedge clock) begin
      if (cmd.enq_rd || cmd.deq_rd) begin
         head_rd_ff <= head_mem[rd_addr];
         tail_rd_ff <= tail_mem[rd_addr];
      end
      if (cmd.deq_link) begin
         link_rd_ff <= link_mem[head_rd_ff];
      end
      if (cmd.enq_wr && (!ready_ff[prio_ff] || at_head)) begin
         head_mem[prio_ff] <= tid_ff;
      end else if (cmd.deq_wr && !tail_hit_ff) begin
         head_mem[deq_prio_ff] <= link_rd_ff;
      end
      if (cmd.enq_wr && (!ready_ff[prio_ff] || !at_head)) begin
         tail_mem[prio_ff] <= tid_ff;
      end
      if (cmd.enq_wr && ready_ff[prio_ff]) begin
         link_mem[at_head ? tid_ff : tail_rd_ff] <= at_head ? head_rd_ff : tid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.deq_rd) begin
         deq_prio_ff <= p_sel;
      end
      if (cmd.deq_link) begin
         chosen_ff   <= head_rd_ff;
         tail_hit_ff <= (tail_rd_ff == head_rd_ff);
      end
   end

   // bitmaps, item status and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         ready_ff     <= '0;
         queued_ff    <= '0;
         valid_ff     <= 1'b0;
         status_ff    <= STATUS_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.enq_wr) begin
            ready_ff[prio_ff] <= 1'b1;
            queued_ff[tid_ff] <= 1'b1;
         end
         if (cmd.deq_wr) begin
            if (tail_hit_ff) begin
               ready_ff[deq_prio_ff] <= 1'b0;
            end
            queued_ff[chosen_ff] <= 1'b0;
            valid_ff             <= 1'b1;
         end
         if (cmd.latch) begin
            valid_ff  <= 1'b0;
            status_ff <= STATUS_OK;
         end
         if (cmd.enq_check && stat.enq_skip && tid_ok_ff) begin
            status_ff <= STATUS_QUEUED;
         end
         if (cmd.deq_rd && !stat.deq_any) begin
            status_ff <= STATUS_EMPTY;
         end
         if (cmd.load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_data_ff.chosen_id    <= valid_ff ? ID_W'(chosen_ff) : '0;
         rsp_data_ff.chosen_valid <= valid_ff;
         rsp_data_ff.status       <= status_ff;
      end
   end

   assign stat.enq_skip = !tid_ok_ff || queued_ff[tid_ff];
   assign stat.deq_any  = |grp_any_ff;
   assign stat.rsp_busy = rsp_valid_ff && !rsp_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: rtl/priority_ready_queue_scheduler.sv
// Channel   Ports                              Carries
// request   req_valid / req_ready / req_data   func, tid, priority_req
// response  rsp_valid / rsp_ready / rsp_data   chosen_id, chosen_valid, status
//
// Enqueue reads head/tail, then writes head/tail/link unless refused (queued already or id out
// of range); dequeue scans ready bits, reads head/tail, then if not empty reads the link and
// writes the head. Yield does both. Each loads the result, then reopens the request side.
// Synchronous active-high reset clears bitmaps and control; queue memories need no sweep.
// The result register lets the next request transfer while a result waits.

`include "priority_ready_queue_scheduler_defines.svh"

module priority_ready_queue_scheduler #(
   parameter int NUM_PRIORITIES = 32,
   parameter int NUM_THREADS    = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  prqs_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output prqs_pkg::rsp_type rsp_data
);
   import prqs_pkg::*;

   // command and status between sequencer and datapath
   cmd_type  cmd;
   stat_type stat;

   // sequencer: walks enqueue, scan, dequeue and result phases
   prqs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_func  (req_data.func),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // datapath: bitmaps, per-priority head/tail, per-thread links, result reg
   prqs_dpath #(
      .NUM_PRIORITIES (NUM_PRIORITIES),
      .NUM_THREADS    (NUM_THREADS)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // at most one datapath command per cycle
   `PRQS_ASSERT_NOW(a_cmd_onehot, clock, reset, 1'b1, $onehot0(cmd), "overlapping commands")
   // never overwrite a result that has not transferred
   `PRQS_ASSERT_NOW(a_load_free, clock, reset, cmd.load_rsp, !stat.rsp_busy, "result overwritten")
   // a transfer in closes the request side until the item is done
   `PRQS_ASSERT_NEXT(a_one_item, clock, reset, req_valid && req_ready, !req_ready, "second item taken")
   // a result appears only after a load
   `PRQS_ASSERT_NEXT(a_rsp_from_load, clock, reset, !rsp_valid && !cmd.load_rsp, !rsp_valid, "spurious result")

endmodule
